>>> design/bbse_pkg.sv
package bbse_pkg;

	// default stack depth in 64-bit words
	localparam int unsigned STACK_DEPTH_DEF = 32;

	localparam int unsigned WORD_W = 64;

	typedef enum logic [3:0] {
		OP_VAR   = 4'd0,
		OP_AND   = 4'd1,
		OP_OR    = 4'd2,
		OP_XOR   = 4'd3,
		OP_NOT   = 4'd4,
		OP_IMP   = 4'd5,
		OP_NAND  = 4'd6,
		OP_NOR   = 4'd7,
		OP_XNOR  = 4'd8
	} op_t;

	// one instruction as held in the input stage
	typedef struct packed {
		logic [3:0]  req_type;
		logic [3:0]  var_index;
		logic [15:0] row_index;
		logic        last_instr;
	} instr_t;

	// end-of-program result
	typedef struct packed {
		logic [WORD_W-1:0] truth_word;
		logic              stack_error;
	} result_t;

	// bit pattern of one variable over a 64-row block
	function automatic logic [WORD_W-1:0] var_word(input logic [3:0] vi,
	                                               input logic [15:0] row);
		logic [WORD_W-1:0] w;
		case (vi)
			4'd0:    w = 64'hAAAA_AAAA_AAAA_AAAA;
			4'd1:    w = 64'hCCCC_CCCC_CCCC_CCCC;
			4'd2:    w = 64'hF0F0_F0F0_F0F0_F0F0;
			4'd3:    w = 64'hFF00_FF00_FF00_FF00;
			4'd4:    w = 64'hFFFF_0000_FFFF_0000;
			4'd5:    w = 64'hFFFF_FFFF_0000_0000;
			default: w = {WORD_W{row[vi]}};
		endcase
		return w;
	endfunction

endpackage

>>> design/bbse_alu.sv
module bbse_alu
	import bbse_pkg::*;
(
	input  logic [3:0]        req_type,
	input  logic [3:0]        var_index,
	input  logic [15:0]       row_index,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output logic [WORD_W-1:0] word
);

	// a is the lower operand, b the top of stack
	always_comb begin
		case (req_type)
			OP_VAR:   word = var_word(var_index, row_index);
			OP_AND:   word = a & b;
			OP_OR:    word = a | b;
			OP_XOR:   word = a ^ b;
			OP_NOT:   word = ~b;
			OP_IMP:   word = ~a | b;
			OP_NAND:  word = ~(a & b);
			OP_NOR:   word = ~(a | b);
			OP_XNOR:  word = ~(a ^ b);
			default:  word = b;
		endcase
	end

endmodule

>>> design/bbse_stack.sv
module bbse_stack
	import bbse_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  instr_t  instr,
	output result_t result
);

	localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [LW-1:0]     level_q;
	logic              err_q;
	logic [WORD_W-1:0] tos_q;
	logic [WORD_W-1:0] nos_q;
	logic [WORD_W-1:0] spill_q;
	logic [WORD_W-1:0] mem [STACK_DEPTH];

	logic              is_var, is_not, is_bin, full;
	logic              do_push, do_not, do_bin, err_now;
	logic [WORD_W-1:0] alu_word, tos_n, nos_n;
	logic [LW-1:0]     level_n, wa_full, ra_full;
	logic              err_n;
	logic [IW-1:0]     wa, ra;

	bbse_alu u_alu (
		.req_type  (instr.req_type),
		.var_index (instr.var_index),
		.row_index (instr.row_index),
		.a         (nos_q),
		.b         (tos_q),
		.word      (alu_word)
	);

	always_comb begin
		is_var  = (instr.req_type == OP_VAR);
		is_not  = (instr.req_type == OP_NOT);
		is_bin  = !is_var && !is_not && (instr.req_type <= OP_XNOR);
		full    = (level_q == LW'(STACK_DEPTH));
		do_push = is_var && !full;
		do_not  = is_not && (level_q != '0);
		do_bin  = is_bin && (level_q >= LW'(2));
		err_now = (is_var && full) || (is_not && (level_q == '0))
		          || (is_bin && (level_q < LW'(2)));

		tos_n = (do_push || do_not || do_bin) ? alu_word : tos_q;
		nos_n = do_push ? tos_q : (do_bin ? spill_q : nos_q);
		if (do_push)
			level_n = level_q + LW'(1);
		else if (do_bin)
			level_n = level_q - LW'(1);
		else
			level_n = level_q;
		err_n = err_q | err_now;

		// memory holds all words below the top two
		wa_full = level_q - LW'(2);
		ra_full = level_q - LW'(4);
		wa      = wa_full[IW-1:0];
		ra      = ra_full[IW-1:0];

		result.truth_word  = (level_n == '0) ? '0 : tos_n;
		result.stack_error = (level_n == '0) | err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			err_q   <= 1'b0;
		end else if (go) begin
			if (instr.last_instr) begin
				level_q <= '0;
				err_q   <= 1'b0;
			end else begin
				level_q <= level_n;
				err_q   <= err_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			tos_q <= tos_n;
			nos_q <= nos_n;
		end
	end

	// spill_q mirrors the memory top word, forwarded on a push
	always_ff @(posedge clk) begin
		if (go && do_push) begin
			if (level_q >= LW'(2))
				mem[wa] <= nos_q;
			spill_q <= nos_q;
		end else if (go && do_bin) begin
			spill_q <= mem[ra];
		end
	end

endmodule

>>> design/bitsliced_boolean_stack_evaluator_core.sv
// Bit-sliced Boolean stack evaluator: runs a postfix Boolean program, one
// instruction per input beat, over a block of 64 truth-table rows, each stack
// word carrying one bit per row. Variables 0 to 5 push the usual alternating
// masks, higher variables push all ones or all zeros from the matching bit of
// row_index. Binary ops pop two words and push the result, NOT complements the
// top word. The beat marked tlast ends the program: one result beat carries the
// top word and a sticky error flag (underflow, overflow or empty stack at the
// end) and the stack is emptied for the next program. Non-final beats give no
// output. One instruction per clock is sustained, also for back-to-back binary
// ops, unless a final beat waits on a full result register: the top two words
// live in registers, the rest in a memory with one write and one registered
// read port, next word prefetched. A final beat passes the input register, then
// the result register. No clearing after reset; only pushed words are used.
module bitsliced_boolean_stack_evaluator_core
	import bbse_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// instruction stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // req_type[3:0], var_index[7:4], row_index[23:8]
	input  logic        s_axis_tlast,   // last_instr

	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // truth_word[63:0]
	output logic [0:0]  m_axis_tuser    // stack_error[0]
);

	logic    valid_s1;
	instr_t  instr_s1;
	logic    advance;
	logic    s_accept;
	result_t result;
	logic    out_valid_q;
	result_t out_q;

	// only a final beat needs the result register free
	assign advance  = valid_s1 && (!instr_s1.last_instr || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept = s_axis_tvalid && s_axis_tready;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			instr_s1.req_type   <= s_axis_tdata[3:0];
			instr_s1.var_index  <= s_axis_tdata[7:4];
			instr_s1.row_index  <= s_axis_tdata[23:8];
			instr_s1.last_instr <= s_axis_tlast;
		end
	end

	// stack state, operand registers and spill memory
	bbse_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.instr  (instr_s1),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && instr_s1.last_instr) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && instr_s1.last_instr) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_q.truth_word;
	assign m_axis_tuser[0] = out_q.stack_error;

endmodule
